// ===== hw/rtl/ps2_keyboard_receiver_macros.svh =====
// assertion macros for the ps2 keyboard receiver checker
`ifndef PS2_KEYBOARD_RECEIVER_MACROS_SVH
`define PS2_KEYBOARD_RECEIVER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PS2KR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2kr check failed");

// next-cycle implication, sampled on clk, off during reset
`define PS2KR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2kr check failed");

`endif

// ===== hw/rtl/ps2kr_pkg.sv =====
// shared types and constants for the ps2 keyboard receiver
`default_nettype none

package ps2kr_pkg;

	localparam int EDGE_TIME_W     = 32;
	localparam int TIMEOUT_W       = 20;
	localparam int TIME_WIDTH_DEF  = 32;
	localparam int MOD_W           = 6;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd3000;

	localparam logic [7:0] CODE_EXT   = 8'hE0;
	localparam logic [7:0] CODE_REL   = 8'hF0;
	localparam logic [7:0] KEY_LSHIFT = 8'h12;
	localparam logic [7:0] KEY_RSHIFT = 8'h59;
	localparam logic [7:0] KEY_ALT    = 8'h11;
	localparam logic [7:0] KEY_CTRL   = 8'h14;
	localparam logic [7:0] KEY_CAPS   = 8'h58;
	localparam logic [7:0] KEY_SCROLL = 8'h7E;
	localparam logic [7:0] KEY_NUM    = 8'h77;

	localparam int MOD_SHIFT  = 0;
	localparam int MOD_ALT    = 1;
	localparam int MOD_CTRL   = 2;
	localparam int MOD_CAPS   = 3;
	localparam int MOD_SCROLL = 4;
	localparam int MOD_NUM    = 5;

	typedef struct packed {
		logic [EDGE_TIME_W-1:0] edge_time;
		logic                   data_bit;
	} ps2kr_in_t;

	typedef struct packed {
		logic             released;
		logic [7:0]       keycode;
		logic [MOD_W-1:0] modifier_bits;
	} ps2kr_out_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} ps2kr_byte_t;

	typedef struct packed {
		logic       valid;
		ps2kr_out_t data;
	} ps2kr_res_t;

	typedef enum logic [1:0] {
		FR_HUNT,
		FR_DATA,
		FR_PARITY,
		FR_STOP
	} ps2kr_frame_state_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_EXT,
		SEQ_REL
	} ps2kr_seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_keyboard_receiver.sv =====
// a key event passes the input register, then the result register, before it is offered
// throughput: one ps2 clock edge per cycle unless stalled, as frame and decode update on every advance
// a full result register that is not taken stalls the input register behind it
// reset: frame hunts for a start bit, decoder idle, modifiers clear, timeout 3000 ticks
`default_nettype none

module ps2_keyboard_receiver #(
	parameter int TIME_WIDTH = ps2kr_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ps2kr_pkg::ps2kr_in_t           in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ps2kr_pkg::ps2kr_out_t               out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ps2kr_pkg::TIMEOUT_W-1:0] cfg_data
);

	logic                              valid_s1;
	ps2kr_pkg::ps2kr_in_t              data_s1;
	logic                              out_valid_q;
	ps2kr_pkg::ps2kr_out_t             out_data_q;
	logic [ps2kr_pkg::TIMEOUT_W-1:0]   timeout_q;
	logic                              advance;
	ps2kr_pkg::ps2kr_byte_t            rx_byte;
	ps2kr_pkg::ps2kr_res_t             res;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ps2kr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	ps2kr_frame #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.edge_time(data_s1.edge_time),
		.data_bit (data_s1.data_bit),
		.timeout  (timeout_q),
		.rx_byte  (rx_byte)
	);

	ps2kr_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(rx_byte),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_data_q <= res.data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2kr_frame.sv =====
// frame receiver: start, data, parity and stop bits with edge timeout
`default_nettype none

module ps2kr_frame #(
	parameter int TIME_WIDTH = ps2kr_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire logic [ps2kr_pkg::EDGE_TIME_W-1:0] edge_time,
	input  wire logic                             data_bit,
	input  wire logic [ps2kr_pkg::TIMEOUT_W-1:0]   timeout,
	output ps2kr_pkg::ps2kr_byte_t                rx_byte
);

	localparam int CMP_W = (TIME_WIDTH > ps2kr_pkg::TIMEOUT_W) ?
		TIME_WIDTH : ps2kr_pkg::TIMEOUT_W;

	ps2kr_pkg::ps2kr_frame_state_t state_q, state_d;
	logic [2:0]            cnt_q, cnt_d;
	logic [7:0]            shift_q, shift_d;
	logic                  parity_q, parity_d;
	logic [TIME_WIDTH-1:0] prev_time_q;
	logic                  edge_seen_q;
	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] gap;
	logic                  late;

	generate
		if (TIME_WIDTH > ps2kr_pkg::EDGE_TIME_W) begin : g_ext
			assign now = {{(TIME_WIDTH - ps2kr_pkg::EDGE_TIME_W){1'b0}}, edge_time};
		end else begin : g_trunc
			assign now = edge_time[TIME_WIDTH-1:0];
		end
	endgenerate

	assign gap  = now - prev_time_q;
	assign late = edge_seen_q && (CMP_W'(gap) > CMP_W'(timeout));

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		shift_d       = shift_q;
		parity_d      = parity_q;
		rx_byte.valid = 1'b0;
		rx_byte.data  = shift_q;
		unique case (state_q)
			ps2kr_pkg::FR_HUNT: begin
				if (!data_bit) begin
					state_d = ps2kr_pkg::FR_DATA;
					cnt_d   = 3'd0;
					shift_d = 8'd0;
				end
			end
			ps2kr_pkg::FR_DATA: begin
				if (late) begin
					cnt_d   = 3'd0;
					shift_d = 8'd0;
				end else begin
					shift_d[cnt_q] = data_bit;
					if (cnt_q == 3'd7) begin
						state_d = ps2kr_pkg::FR_PARITY;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			ps2kr_pkg::FR_PARITY: begin
				if (late) begin
					state_d = ps2kr_pkg::FR_DATA;
					cnt_d   = 3'd0;
					shift_d = 8'd0;
				end else begin
					parity_d = data_bit;
					state_d  = ps2kr_pkg::FR_STOP;
				end
			end
			ps2kr_pkg::FR_STOP: begin
				if (late) begin
					state_d = ps2kr_pkg::FR_DATA;
					cnt_d   = 3'd0;
					shift_d = 8'd0;
				end else begin
					state_d       = ps2kr_pkg::FR_HUNT;
					rx_byte.valid = (^{shift_q, parity_q}) && data_bit;
				end
			end
			default: begin
				state_d = ps2kr_pkg::FR_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ps2kr_pkg::FR_HUNT;
			cnt_q       <= 3'd0;
			shift_q     <= 8'd0;
			parity_q    <= 1'b0;
			prev_time_q <= '0;
			edge_seen_q <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			shift_q     <= shift_d;
			parity_q    <= parity_d;
			prev_time_q <= now;
			edge_seen_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2kr_decode.sv =====
// scan code sequence decoder and modifier tracking
`default_nettype none

module ps2kr_decode (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire ps2kr_pkg::ps2kr_byte_t rx_byte,
	output ps2kr_pkg::ps2kr_res_t       res
);

	ps2kr_pkg::ps2kr_seq_state_t   seq_q, seq_d;
	logic [ps2kr_pkg::MOD_W-1:0]   mods_q, mods_d;
	logic                          emit;
	logic                          rel;
	logic [7:0]                    b;

	assign b = rx_byte.data;

	always_comb begin
		seq_d  = seq_q;
		mods_d = mods_q;
		emit   = 1'b0;
		rel    = 1'b0;
		if (rx_byte.valid) begin
			unique case (seq_q)
				ps2kr_pkg::SEQ_REL: begin
					emit = 1'b1;
					rel  = 1'b1;
				end
				ps2kr_pkg::SEQ_EXT: begin
					if (b == ps2kr_pkg::CODE_REL) begin
						seq_d = ps2kr_pkg::SEQ_REL;
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
					if (b == ps2kr_pkg::CODE_REL) begin
						seq_d = ps2kr_pkg::SEQ_REL;
					end else if (b == ps2kr_pkg::CODE_EXT) begin
						seq_d = ps2kr_pkg::SEQ_EXT;
					end else begin
						emit = 1'b1;
					end
				end
			endcase
			if (emit) begin
				seq_d = ps2kr_pkg::SEQ_IDLE;
				if (b == ps2kr_pkg::KEY_LSHIFT || b == ps2kr_pkg::KEY_RSHIFT) begin
					mods_d[ps2kr_pkg::MOD_SHIFT] = !rel;
				end
				if (b == ps2kr_pkg::KEY_ALT) begin
					mods_d[ps2kr_pkg::MOD_ALT] = !rel;
				end
				if (b == ps2kr_pkg::KEY_CTRL) begin
					mods_d[ps2kr_pkg::MOD_CTRL] = !rel;
				end
				if (!rel) begin
					if (b == ps2kr_pkg::KEY_CAPS) begin
						mods_d[ps2kr_pkg::MOD_CAPS] = !mods_q[ps2kr_pkg::MOD_CAPS];
					end
					if (b == ps2kr_pkg::KEY_SCROLL) begin
						mods_d[ps2kr_pkg::MOD_SCROLL] = !mods_q[ps2kr_pkg::MOD_SCROLL];
					end
					if (b == ps2kr_pkg::KEY_NUM) begin
						mods_d[ps2kr_pkg::MOD_NUM] = !mods_q[ps2kr_pkg::MOD_NUM];
					end
				end
			end
		end
		res.valid              = emit;
		res.data.released      = rel;
		res.data.keycode       = b;
		res.data.modifier_bits = mods_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= ps2kr_pkg::SEQ_IDLE;
			mods_q <= '0;
		end else if (step) begin
			seq_q  <= seq_d;
			mods_q <= mods_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2kr_checker.sv =====
// port-level checker for the ps2 keyboard receiver, bound to the top level
`default_nettype none

`include "ps2_keyboard_receiver_macros.svh"

module ps2kr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire ps2kr_pkg::ps2kr_in_t            in_data,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire ps2kr_pkg::ps2kr_out_t           out_data,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready,
	input wire logic [ps2kr_pkg::TIMEOUT_W-1:0] cfg_data
);

	// stalled result transaction holds
	`PS2KR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// input only stalls behind a result that is not taken
	`PS2KR_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready)

	// a new result comes from an input transaction that passed the input register
	`PS2KR_ASSERT_IMPL(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 2))

	// config writes are never held off
	`PS2KR_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind ps2_keyboard_receiver ps2kr_checker u_ps2kr_checker (.*);

`default_nettype wire
